FILE: rtl/json_string_unescape_utf8_defines.svh
// Assertion helpers shared by the queue and the back end.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Checks a property on every rising edge of clk outside reset.
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define JSU_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/jsu_pkg.sv
package jsu_pkg;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_NO_QUOTE   = 4'd1;
  localparam logic [3:0] ERR_CTRL       = 4'd2;
  localparam logic [3:0] ERR_BAD_ESC    = 4'd3;
  localparam logic [3:0] ERR_BAD_HEX    = 4'd4;
  localparam logic [3:0] ERR_MISS_LOW   = 4'd5;
  localparam logic [3:0] ERR_BAD_LOW    = 4'd6;
  localparam logic [3:0] ERR_LONE_LOW   = 4'd7;
  localparam logic [3:0] ERR_UNTERM     = 4'd8;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U = 8'h75;

  // One request from the front end: up to four result bytes.
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  err;
    logic [20:0] cp;
    logic [1:0]  nlast;
  } entry_t;

  // Bit 4 set means the character is no hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

  // Bit 8 set means the escape letter is unknown.
  function automatic logic [8:0] esc_value(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h22:   r = 9'h022;
      8'h5C:   r = 9'h05C;
      8'h2F:   r = 9'h02F;
      8'h62:   r = 9'h008;
      8'h66:   r = 9'h00C;
      8'h6E:   r = 9'h00A;
      8'h72:   r = 9'h00D;
      8'h74:   r = 9'h009;
      default: r = 9'h100;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] nlast,
                                           input logic [1:0] idx);
    logic [7:0] r;
    logic [3:0] sel;
    sel = {nlast, idx};
    unique case (sel)
      4'b01_00: r = {3'b110, cp[10:6]};
      4'b10_00: r = {4'b1110, cp[15:12]};
      4'b10_01: r = {2'b10, cp[11:6]};
      4'b11_00: r = {5'b11110, cp[20:18]};
      4'b11_01: r = {2'b10, cp[17:12]};
      4'b11_10: r = {2'b10, cp[11:6]};
      4'b01_01, 4'b10_10, 4'b11_11: r = {2'b10, cp[5:0]};
      default:  r = cp[7:0];
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/jsu_front.sv
module jsu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [7:0]       text_byte,
  output logic             req_push,
  output jsu_pkg::entry_t  req
);

  localparam logic [2:0] MODE_WAIT    = 3'd0;
  localparam logic [2:0] MODE_TEXT    = 3'd1;
  localparam logic [2:0] MODE_ESC     = 3'd2;
  localparam logic [2:0] MODE_HEX_HI  = 3'd3;
  localparam logic [2:0] MODE_NEED_BS = 3'd4;
  localparam logic [2:0] MODE_NEED_U  = 3'd5;
  localparam logic [2:0] MODE_HEX_LO  = 3'd6;

  logic [2:0]  mode_r, mode_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  hs_r, hs_nxt;

  logic        do_fail;
  logic [3:0]  fail_code;
  logic [4:0]  hv;
  logic [8:0]  ev;
  logic [15:0] acc_sh;
  logic        digit_done;
  logic [10:0] plane;

  always_comb begin
    hv         = jsu_pkg::hex_value(text_byte);
    ev         = jsu_pkg::esc_value(text_byte);
    acc_sh     = {hex_r[11:0], hv[3:0]};
    digit_done = (cnt_r == 2'd3);
    plane      = {1'b0, hs_r} + 11'h040;
    mode_nxt   = mode_r;
    hex_nxt    = hex_r;
    cnt_nxt    = cnt_r;
    hs_nxt     = hs_r;
    do_fail    = 1'b0;
    fail_code  = jsu_pkg::ERR_NONE;
    req_push   = 1'b0;
    req        = '0;
    if (mode_r == MODE_WAIT) begin
      if (text_byte == jsu_pkg::CH_QUOTE) begin
        mode_nxt = MODE_TEXT;
        hex_nxt  = '0;
        cnt_nxt  = '0;
        hs_nxt   = '0;
      end else begin
        do_fail   = 1'b1;
        fail_code = jsu_pkg::ERR_NO_QUOTE;
      end
    end else if (text_byte == 8'h00) begin
      do_fail   = 1'b1;
      fail_code = jsu_pkg::ERR_UNTERM;
    end else begin
      unique case (mode_r)
        MODE_TEXT: begin
          if (text_byte == jsu_pkg::CH_QUOTE) begin
            req_push = 1'b1;
            req.kind = jsu_pkg::KIND_DONE;
            mode_nxt = MODE_WAIT;
            hex_nxt  = '0;
            cnt_nxt  = '0;
            hs_nxt   = '0;
          end else if (text_byte < 8'h20) begin
            do_fail   = 1'b1;
            fail_code = jsu_pkg::ERR_CTRL;
          end else if (text_byte == jsu_pkg::CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else begin
            req_push = 1'b1;
            req.cp   = {13'b0, text_byte};
          end
        end
        MODE_ESC: begin
          if (text_byte == jsu_pkg::CH_U) begin
            hex_nxt  = '0;
            cnt_nxt  = '0;
            mode_nxt = MODE_HEX_HI;
          end else if (!ev[8]) begin
            req_push = 1'b1;
            req.cp   = {13'b0, ev[7:0]};
            mode_nxt = MODE_TEXT;
          end else begin
            do_fail   = 1'b1;
            fail_code = jsu_pkg::ERR_BAD_ESC;
          end
        end
        MODE_HEX_HI, MODE_HEX_LO: begin
          if (hv[4]) begin
            do_fail   = 1'b1;
            fail_code = jsu_pkg::ERR_BAD_HEX;
          end else begin
            hex_nxt = acc_sh;
            cnt_nxt = cnt_r + 2'd1;
            if (digit_done && mode_r == MODE_HEX_HI) begin
              if (acc_sh >= 16'hD800 && acc_sh <= 16'hDBFF) begin
                hs_nxt   = acc_sh[9:0];
                mode_nxt = MODE_NEED_BS;
              end else if (acc_sh >= 16'hDC00 && acc_sh <= 16'hDFFF) begin
                do_fail   = 1'b1;
                fail_code = jsu_pkg::ERR_LONE_LOW;
              end else begin
                req_push = 1'b1;
                req.cp   = {5'b0, acc_sh};
                if (acc_sh <= 16'h007F) req.nlast = 2'd0;
                else if (acc_sh <= 16'h07FF) req.nlast = 2'd1;
                else req.nlast = 2'd2;
                mode_nxt = MODE_TEXT;
              end
            end else if (digit_done) begin
              if (acc_sh < 16'hDC00 || acc_sh > 16'hDFFF) begin
                do_fail   = 1'b1;
                fail_code = jsu_pkg::ERR_BAD_LOW;
              end else begin
                req_push  = 1'b1;
                req.cp    = {plane, acc_sh[9:0]};
                req.nlast = 2'd3;
                hex_nxt   = '0;
                hs_nxt    = '0;
                mode_nxt  = MODE_TEXT;
              end
            end
          end
        end
        MODE_NEED_BS: begin
          if (text_byte == jsu_pkg::CH_BSLASH) begin
            mode_nxt = MODE_NEED_U;
          end else begin
            do_fail   = 1'b1;
            fail_code = jsu_pkg::ERR_MISS_LOW;
          end
        end
        MODE_NEED_U: begin
          if (text_byte == jsu_pkg::CH_U) begin
            hex_nxt  = '0;
            cnt_nxt  = '0;
            mode_nxt = MODE_HEX_LO;
          end else begin
            do_fail   = 1'b1;
            fail_code = jsu_pkg::ERR_MISS_LOW;
          end
        end
        default: begin
          mode_nxt = MODE_WAIT;
          hex_nxt  = '0;
          cnt_nxt  = '0;
          hs_nxt   = '0;
        end
      endcase
    end
    if (do_fail) begin
      req_push  = 1'b1;
      req       = '0;
      req.kind  = jsu_pkg::KIND_ERR;
      req.err   = fail_code;
      mode_nxt  = MODE_WAIT;
      hex_nxt   = '0;
      cnt_nxt   = '0;
      hs_nxt    = '0;
    end
    req_push = req_push & take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_WAIT;
      hex_r  <= '0;
      cnt_r  <= '0;
      hs_r   <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      hex_r  <= hex_nxt;
      cnt_r  <= cnt_nxt;
      hs_r   <= hs_nxt;
    end
  end

endmodule

FILE: rtl/jsu_fifo.sv
`include "json_string_unescape_utf8_defines.svh"

module jsu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  jsu_pkg::entry_t  wdata,
  output logic             full,
  input  logic             pop,
  output jsu_pkg::entry_t  rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (do_pop) rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      if (do_push && !do_pop) count_r <= count_r + CW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CW'(1);
    end
  end

  `JSU_NEVER(a_fifo_count_range, count_r > CW'(DEPTH), "queue count beyond its depth")
  `JSU_ASSERT(a_fifo_count_up, rst_n && do_push && !do_pop |=> count_r == $past(count_r) + CW'(1), "queue count did not rise on a lone push")

endmodule

FILE: rtl/jsu_back.sv
`include "json_string_unescape_utf8_defines.svh"

module jsu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  jsu_pkg::entry_t  q_data,
  input  logic             q_empty,
  output logic             q_pop,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_result_kind,
  output logic [3:0]       out_error_code,
  output logic             out_last_of_run,
  output logic             empty,
  input  logic             pop
);

  jsu_pkg::entry_t cur_r;
  logic            cur_valid_r;
  logic [1:0]      idx_r;
  logic            last;
  logic            done_cur;

  assign last            = (idx_r == cur_r.nlast);
  assign done_cur        = cur_valid_r && pop && last;
  assign q_pop           = !q_empty && (!cur_valid_r || done_cur);
  assign empty           = !cur_valid_r;
  assign out_byte        = jsu_pkg::utf8_byte(cur_r.cp, cur_r.nlast, idx_r);
  assign out_result_kind = cur_r.kind;
  assign out_error_code  = cur_r.err;
  assign out_last_of_run = last;

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (done_cur) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (cur_valid_r && pop) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  `JSU_NEVER(a_back_idx_range, cur_valid_r && idx_r > cur_r.nlast, "byte index past the end of its request")
  `JSU_NEVER(a_back_single_status, cur_valid_r && cur_r.kind != jsu_pkg::KIND_DATA && cur_r.nlast != 2'd0, "status request spans several results")

endmodule

FILE: rtl/json_string_unescape_utf8.sv
// JSON string unescaper with UTF-8 output.
// Input channel: drive in_text_byte and raise push; the byte is taken at a
// rising edge where push is high and full is low. The first byte of a string
// must be the opening quote; a zero byte marks the end of the text.
// Result channel: while empty is low the oldest result sits on out_byte,
// out_result_kind, out_error_code and out_last_of_run; raise pop to take it.
// Each input byte gives no result, one result, or a run of up to four UTF-8
// bytes, with out_last_of_run set on the final result of the run.
// A byte is decoded in the cycle it is taken; its request is queued, then
// loaded into the output register; its first result reaches the result ports
// when no earlier result waits, else it waits behind those. One byte is taken
// every cycle while full is low; the result side drains one result a cycle
// while pop is high, so a burst of multibyte escapes is absorbed by a request
// queue of DEPTH entries between decoder and output. When the receiver stalls,
// the queue fills and full rises; nothing is lost. A synchronous reset on rst_n
// empties the queue and returns the decoder to waiting for an opening quote.
module json_string_unescape_utf8 #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_text_byte,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_byte,
  output logic [1:0] out_result_kind,
  output logic [3:0] out_error_code,
  output logic       out_last_of_run,
  output logic       empty,
  input  logic       pop
);

  logic            take;
  logic            req_push;
  jsu_pkg::entry_t req;
  jsu_pkg::entry_t q_data;
  logic            q_full, q_empty, q_pop;

  assign full = q_full;
  assign take = push && !q_full;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .text_byte (in_text_byte),
    .req_push  (req_push),
    .req       (req)
  );

  jsu_fifo #(.DEPTH(DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (req_push),
    .wdata (req),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  jsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_data          (q_data),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_byte        (out_byte),
    .out_result_kind (out_result_kind),
    .out_error_code  (out_error_code),
    .out_last_of_run (out_last_of_run),
    .empty           (empty),
    .pop             (pop)
  );

endmodule
